// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, off during reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define NRL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define NRL_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hdl/nrl_pkg.sv -----
// ---------------------------------------------------------------------------
// nrl_pkg
// types, sizes, codes and key normalisation for the name registry table
// ---------------------------------------------------------------------------
`default_nettype none

package nrl_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int NAME_BYTES  = 8;
    localparam int KEY_W       = 64;
    localparam int ID_W        = 8;
    localparam int ST_W        = 2;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam logic ACT_REGISTER = 1'b0;
    localparam logic ACT_LOOKUP   = 1'b1;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
    } entry_t;

    typedef struct packed {
        logic            vld;
        logic            hit;
        logic [ID_W-1:0] id;
    } tok_t;

    // keep bytes up to the first zero byte, at most NAME_BYTES of them
    function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] res;
        logic             stop;
        res  = '0;
        stop = 1'b0;
        for (int i = 0; i < NAME_BYTES; i++)
        begin
            if (raw[8*i +: 8] == 8'h00)
            begin
                stop = 1'b1;
            end
            if (!stop)
            begin
                res[8*i +: 8] = raw[8*i +: 8];
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/nrl_if.sv -----
// ---------------------------------------------------------------------------
// nrl_if
// valid/ready channels for request and response beats
// ---------------------------------------------------------------------------
`default_nettype none

interface nrl_req_if import nrl_pkg::*;;
    logic             valid;
    logic             ready;
    logic             action;
    logic [KEY_W-1:0] name_key;
    logic [ID_W-1:0]  task_id;

    modport source (output valid, output action, output name_key, output task_id,
                    input ready);
    modport sink   (input valid, input action, input name_key, input task_id,
                    output ready);
endinterface

interface nrl_rsp_if import nrl_pkg::*;;
    logic            valid;
    logic            ready;
    logic [ST_W-1:0] status;
    logic [ID_W-1:0] found_id;

    modport source (output valid, output status, output found_id, input ready);
    modport sink   (input valid, input status, input found_id, output ready);
endinterface

`default_nettype wire

// ----- hdl/nrl_cell.sv -----
// ---------------------------------------------------------------------------
// nrl_cell
// one table slot: holds an entry, shifts it on insert, and updates the
// search token that passes through it one cell per cycle
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module nrl_cell import nrl_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             shift_en,
    input  wire logic             occupied,
    input  wire logic [KEY_W-1:0] key,
    input  wire entry_t           entry_in,
    output entry_t                entry_out,
    input  wire tok_t             tok_in,
    output tok_t                  tok_out
);

    entry_t entry_reg;
    tok_t   tok_reg;
    tok_t   tok_next;
    logic   match;

    assign match = occupied && (entry_reg.key == key);

    always_comb
    begin
        tok_next.vld = tok_in.vld;
        tok_next.hit = tok_in.hit | match;
        tok_next.id  = (tok_in.hit || !match) ? tok_in.id : entry_reg.id;
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            entry_reg <= entry_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign entry_out = entry_reg;
    assign tok_out   = tok_reg;

    `NRL_ASSERT(a_hit_kept, tok_in.vld && tok_in.hit |=> tok_reg.hit && (tok_reg.id == $past(tok_in.id)), "newer hit overwritten by older slot")
    `NRL_ASSERT(a_free_no_hit, tok_in.vld && !tok_in.hit && !occupied |=> !tok_reg.hit, "hit on an unused slot")

endmodule

`default_nettype wire

// ----- hdl/name_registry_lookup_table_core.sv -----
// ---------------------------------------------------------------------------
// name_registry_lookup_table_core
// associative name table: register a name with a task id, look up the
// task id of the newest registration of a name
// ---------------------------------------------------------------------------
// req channel: one beat per request (action, name_key, task_id)
// rsp channel: exactly one beat per request (status, found_id), in order
// names are cut at the first zero byte before storage and comparison
// register: stored at the head of the cell row, older entries move one
//   cell down; the response goes through the parked and then the output
//   register; status full once MAX_ENTRIES names are held
// lookup: a search token walks the cell row from newest to oldest, one
//   cell per cycle, and its result is parked once the token leaves the
//   last cell of the row
// one request is in flight at a time; a new request is taken while the
//   previous response still waits in the output register
// reset: table empty, no response pending; stored names need no clearing
// a stalled receiver holds the response; one more finished response is
//   parked behind it and further requests wait
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module name_registry_lookup_table_core import nrl_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    nrl_req_if.sink    req,
    nrl_rsp_if.source  rsp
);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_SEARCH = 1'b1;

    logic             state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [KEY_W-1:0] key_reg;
    logic             start_reg;
    logic             pend_vld_reg, pend_vld_next;
    logic [ST_W-1:0]  pend_status_reg, pend_status_next;
    logic [ID_W-1:0]  pend_id_reg, pend_id_next;
    logic             out_vld_reg, out_vld_next;
    logic [ST_W-1:0]  out_status_reg, out_status_next;
    logic [ID_W-1:0]  out_id_reg, out_id_next;

    logic             req_acc;
    logic             is_reg;
    logic             full;
    logic             shift_en;
    logic [KEY_W-1:0] key_norm;
    logic [MAX_ENTRIES-1:0] occ;
    entry_t           ent_link [MAX_ENTRIES];
    tok_t             tok_link [MAX_ENTRIES+1];

    assign req.ready = (state_reg == S_IDLE) && !pend_vld_reg;
    assign req_acc   = req.valid && req.ready;
    assign is_reg    = (req.action == ACT_REGISTER);
    assign full      = (count_reg == CNT_W'(MAX_ENTRIES));
    assign shift_en  = req_acc && is_reg && !full;
    assign key_norm  = norm_key(req.name_key);

    assign ent_link[0] = '{key: key_norm, id: req.task_id};
    assign tok_link[0] = '{vld: start_reg, hit: 1'b0, id: '0};

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        assign occ[i] = (count_reg > CNT_W'(i));
        if (i == MAX_ENTRIES - 1)
        begin : g_last
            nrl_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift_en  (shift_en),
                .occupied  (occ[i]),
                .key       (key_reg),
                .entry_in  (ent_link[i]),
                .entry_out (),
                .tok_in    (tok_link[i]),
                .tok_out   (tok_link[i+1])
            );
        end
        else
        begin : g_mid
            nrl_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift_en  (shift_en),
                .occupied  (occ[i]),
                .key       (key_reg),
                .entry_in  (ent_link[i]),
                .entry_out (ent_link[i+1]),
                .tok_in    (tok_link[i]),
                .tok_out   (tok_link[i+1])
            );
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        pend_vld_next    = pend_vld_reg;
        pend_status_next = pend_status_reg;
        pend_id_next     = pend_id_reg;
        out_vld_next     = out_vld_reg;
        out_status_next  = out_status_reg;
        out_id_next      = out_id_reg;

        // move parked response into the output register
        if (!out_vld_reg || rsp.ready)
        begin
            out_vld_next    = pend_vld_reg;
            out_status_next = pend_status_reg;
            out_id_next     = pend_id_reg;
            pend_vld_next   = 1'b0;
        end

        if (req_acc)
        begin
            if (is_reg)
            begin
                pend_vld_next    = 1'b1;
                pend_status_next = full ? ST_FULL : ST_OK;
                pend_id_next     = '0;
                if (!full)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            else
            begin
                state_next = S_SEARCH;
            end
        end

        if (tok_link[MAX_ENTRIES].vld)
        begin
            pend_vld_next    = 1'b1;
            pend_status_next = tok_link[MAX_ENTRIES].hit ? ST_OK : ST_NOT_FOUND;
            pend_id_next     = tok_link[MAX_ENTRIES].hit ? tok_link[MAX_ENTRIES].id : '0;
            state_next       = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            start_reg    <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            start_reg    <= req_acc && !is_reg;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            key_reg <= key_norm;
        end
        pend_status_reg <= pend_status_next;
        pend_id_reg     <= pend_id_next;
        out_status_reg  <= out_status_next;
        out_id_reg      <= out_id_next;
    end

    assign rsp.valid    = out_vld_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.found_id = out_id_reg;

    `NRL_ASSERT(a_cnt_max, 1'b1 |-> count_reg <= CNT_W'(MAX_ENTRIES), "entry count past table size")
    `NRL_NEVER(a_acc_busy, (state_reg == S_SEARCH) && req_acc, "request taken during a search")
    `NRL_ASSERT(a_tok_busy, tok_link[MAX_ENTRIES].vld |-> state_reg == S_SEARCH, "search token seen while idle")
    `NRL_ASSERT(a_reg_cnt, req_acc && is_reg && !full |=> count_reg == $past(count_reg) + CNT_W'(1), "register did not grow the table")

endmodule

`default_nettype wire

// ----- verif/tb_name_registry_lookup_table_core.sv -----
// ----------------------------------------------------------------------------
// tb_name_registry_lookup_table_core
// self-checking bench for the name registry lookup table
// ----------------------------------------------------------------------------
// A clocked driver sends register and lookup beats from a queue of pending
// requests. The bench keeps its own copy of the name table. Each request
// accepted by the block updates that copy, and the expected reply is queued.
// A clocked monitor compares each reply beat with the oldest expected reply.
// The directed beats cover the empty table, the empty name, all-ones keys,
// bytes after the name terminator, prefixes and re-registered names. A
// random mix of the same kind follows. It fills the table and then drives
// it past full. Both sides idle in random bursts, and the receiver holds
// off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_name_registry_lookup_table_core;
    import nrl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1680;
    localparam int TAIL_ITEMS   = 150;
    localparam int POOL_SIZE    = 48;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 3000000;

    typedef struct {
        logic             action;
        logic [KEY_W-1:0] name_key;
        logic [ID_W-1:0]  task_id;
    } request_t;

    typedef struct {
        logic [ST_W-1:0] status;
        logic [ID_W-1:0] found_id;
    } reply_t;

    logic clk = 1'b0;
    logic rst_n;

    nrl_req_if req_ch ();
    nrl_rsp_if rsp_ch ();

    name_registry_lookup_table_core dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    request_t         request_queue[$];
    reply_t           expected_replies[$];
    request_t         in_flight;

    logic [KEY_W-1:0] table_keys[MAX_ENTRIES];
    logic [ID_W-1:0]  table_ids[MAX_ENTRIES];
    int               table_used = 0;

    int               beats_sent;
    int               hold_left;
    logic             hold_done;
    int               send_gap = 0;
    int               recv_stall = 0;
    int               cycles = 0;
    int               mismatches = 0;
    int               n_rejected = 0;
    int               n_hits = 0;
    int               n_misses = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // name stops at the first zero byte
    function automatic logic [KEY_W-1:0] trim_name(input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] k;
        int               b;
        k = '0;
        b = 0;
        while (b < NAME_BYTES && raw[8*b +: 8] != 8'h00)
        begin
            k[8*b +: 8] = raw[8*b +: 8];
            b++;
        end
        return k;
    endfunction

    // random bytes behind the terminator
    function automatic logic [KEY_W-1:0] pad_noise(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        int               len;
        r   = k;
        len = 0;
        while (len < 8 && k[8*len +: 8] != 8'h00)
        begin
            len++;
        end
        for (int b = len + 1; b < 8; b++)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                r[8*b +: 8] = 8'($urandom_range(0, 255));
            end
        end
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] random_name();
        logic [KEY_W-1:0] k;
        int               len;
        k   = '0;
        len = $urandom_range(1, 8);
        for (int b = 0; b < len; b++)
        begin
            k[8*b +: 8] = 8'($urandom_range(1, 255));
        end
        return k;
    endfunction

    function automatic reply_t registry_apply(input request_t rq);
        reply_t           rp;
        logic [KEY_W-1:0] k;
        k           = trim_name(rq.name_key);
        rp.found_id = '0;
        if (rq.action == ACT_REGISTER)
        begin
            if (table_used >= MAX_ENTRIES)
            begin
                rp.status = ST_FULL;
            end
            else
            begin
                table_keys[table_used] = k;
                table_ids[table_used]  = rq.task_id;
                table_used++;
                rp.status = ST_OK;
            end
        end
        else
        begin
            rp.status = ST_NOT_FOUND;
            for (int s = table_used - 1; s >= 0; s--)
            begin
                if (table_keys[s] == k)
                begin
                    rp.status   = ST_OK;
                    rp.found_id = table_ids[s];
                    break;
                end
            end
        end
        return rp;
    endfunction

    task automatic queue_request(input logic act, input logic [KEY_W-1:0] key,
                                 input logic [ID_W-1:0] id);
        request_t rq;
        rq.action   = act;
        rq.name_key = key;
        rq.task_id  = id;
        request_queue.push_back(rq);
    endtask

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid    <= 1'b0;
            req_ch.action   <= ACT_REGISTER;
            req_ch.name_key <= '0;
            req_ch.task_id  <= '0;
            beats_sent      <= 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_replies.push_back(registry_apply(in_flight));
                beats_sent <= beats_sent + 1;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (request_queue.size() > 0)
                begin
                    in_flight        = request_queue.pop_front();
                    req_ch.valid    <= 1'b1;
                    req_ch.action   <= in_flight.action;
                    req_ch.name_key <= in_flight.name_key;
                    req_ch.task_id  <= in_flight.task_id;
                    if (request_queue.size() >= TAIL_ITEMS && $urandom_range(0, 9) == 0)
                    begin
                        send_gap = $urandom_range(1, 18);
                    end
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off while requests keep coming
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && beats_sent >= 40)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    flag_mismatch($sformatf("reply beat with none expected (status %0d id %0d)",
                                            rsp_ch.status, rsp_ch.found_id));
                end
                else
                begin
                    reply_t want;
                    want = expected_replies.pop_front();
                    if (rsp_ch.status !== want.status)
                    begin
                        flag_mismatch($sformatf("status %0d, expected %0d",
                                                rsp_ch.status, want.status));
                    end
                    if (rsp_ch.found_id !== want.found_id)
                    begin
                        flag_mismatch($sformatf("found_id %0d, expected %0d",
                                                rsp_ch.found_id, want.found_id));
                    end
                    case (want.status)
                        ST_FULL:      n_rejected++;
                        ST_NOT_FOUND: n_misses++;
                        default:      ;
                    endcase
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
            end
            else if (request_queue.size() >= TAIL_ITEMS && $urandom_range(0, 11) == 0)
            begin
                recv_stall = $urandom_range(1, 18);
            end
            rsp_ch.ready <= (recv_stall == 0) && (hold_left == 0);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [KEY_W-1:0] pool[POOL_SIZE];
        logic [KEY_W-1:0] key;
        int               r;

        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.action   = ACT_REGISTER;
        req_ch.name_key = '0;
        req_ch.task_id  = '0;
        rsp_ch.ready    = 1'b0;

        // directed beats
        queue_request(ACT_LOOKUP,   64'h0000_0000_0000_0061, 8'h00);
        queue_request(ACT_LOOKUP,   64'h0000_0000_0000_0000, 8'h00);
        queue_request(ACT_REGISTER, 64'h0000_0000_0000_0000, 8'h00);
        queue_request(ACT_LOOKUP,   64'hFFFF_FFFF_FFFF_FF00, 8'h00);
        queue_request(ACT_REGISTER, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
        queue_request(ACT_LOOKUP,   64'hFFFF_FFFF_FFFF_FFFF, 8'h00);
        queue_request(ACT_REGISTER, 64'hDEAD_BEEF_0063_6261, 8'h11);
        queue_request(ACT_LOOKUP,   64'h0000_0000_0063_6261, 8'h00);
        queue_request(ACT_LOOKUP,   64'h1234_5678_0063_6261, 8'hEE);
        queue_request(ACT_REGISTER, 64'h0000_0000_0063_6261, 8'h22);
        queue_request(ACT_LOOKUP,   64'h0000_0000_0063_6261, 8'h00);
        queue_request(ACT_LOOKUP,   64'h0000_0000_AB00_6261, 8'h00);
        queue_request(ACT_LOOKUP,   64'h0000_0000_6463_6261, 8'h00);
        queue_request(ACT_REGISTER, 64'h0807_0605_0403_0201, 8'h5A);
        queue_request(ACT_LOOKUP,   64'h8807_0605_0403_0201, 8'h00);
        queue_request(ACT_LOOKUP,   64'h0807_0605_0403_0201, 8'h00);
        queue_request(ACT_REGISTER, 64'h0000_0000_0000_0041, 8'h80);
        queue_request(ACT_LOOKUP,   64'h0000_0000_0000_0041, 8'h00);
        queue_request(ACT_LOOKUP,   64'h0000_0000_0000_0000, 8'h00);
        queue_request(ACT_REGISTER, 64'h0000_0000_6463_6261, 8'h01);
        queue_request(ACT_LOOKUP,   64'h0000_0000_6463_6261, 8'h00);

        // random mix over a small name pool so that names repeat
        pool[0] = 64'h0000_0000_0000_0000;
        pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
        pool[2] = 64'h0000_0000_0063_6261;
        pool[3] = 64'h0807_0605_0403_0201;
        for (int i = 4; i < POOL_SIZE; i++)
        begin
            pool[i] = random_name();
        end
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            r   = $urandom_range(0, 99);
            key = pad_noise(pool[$urandom_range(0, POOL_SIZE - 1)]);
            if (r < 30)
            begin
                if ($urandom_range(0, 9) < 3)
                begin
                    key = {$urandom, $urandom};
                end
                queue_request(ACT_REGISTER, key, 8'($urandom_range(0, 255)));
            end
            else if (r < 90)
            begin
                queue_request(ACT_LOOKUP, key, 8'($urandom_range(0, 255)));
            end
            else
            begin
                queue_request(ACT_LOOKUP, {$urandom, $urandom}, 8'($urandom_range(0, 255)));
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (request_queue.size() != 0 || req_ch.valid)
        begin
            @(posedge clk);
        end
        while (expected_replies.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        n_hits = beats_sent - table_used - n_rejected - n_misses;
        $display("%0d beats: %0d names stored, %0d refused on a full table",
                 beats_sent, table_used, n_rejected);
        $display("lookups: %0d resolved, %0d not found; %0d mismatches",
                 n_hits, n_misses, mismatches);
        if (mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/nrl_pkg.sv
hdl/nrl_if.sv
hdl/nrl_cell.sv
hdl/name_registry_lookup_table_core.sv
verif/tb_name_registry_lookup_table_core.sv
